@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define PDFE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication shorthand on the same clock and reset.
`define PDFE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  `PDFE_ASSERT(lbl, clk, rst, (ante) |-> (cons), msg)

`endif

@@ rtl/core/pdfe_pkg.sv @@
// ---------------------------------------------------------------------------
// pdfe_pkg
// Types and constants shared by the pulse-distance frame encoder.
// ---------------------------------------------------------------------------
package pdfe_pkg;

  // Segment durations in microseconds
  localparam logic [15:0] PULSE_US      = 16'd2212;
  localparam logic [15:0] ONE_GAP_US    = 16'd8144;
  localparam logic [15:0] ZERO_GAP_US   = 16'd4012;
  localparam logic [15:0] END_GAP_US    = 16'd64000;
  localparam logic [15:0] SYNC_LOW_US   = 16'd240;
  localparam logic [15:0] SYNC_HIGH_US  = 16'd1700;
  localparam logic [15:0] TRAIN_HIGH_US = 16'd776;
  localparam logic [15:0] LEAD_LOW_US   = 16'd388;

  // Frame layout
  localparam logic [4:0] CHK_BASE  = 5'd4;
  localparam logic [1:0] MID_CONST = 2'd2;

  // Segment numbering: sync, 14 train pulses, lead, 16 data bits, end gap
  localparam logic [5:0] SEG_SYNC       = 6'd0;
  localparam logic [5:0] SEG_TRAIN_LAST = 6'd14;
  localparam logic [5:0] SEG_LEAD       = 6'd15;
  localparam logic [5:0] SEG_DATA_FIRST = 6'd16;
  localparam logic [5:0] SEG_DATA_LAST  = 6'd31;
  localparam logic [5:0] SEG_END        = 6'd32;

  // Command kinds
  localparam logic [1:0] KIND_SHOCK     = 2'd0;
  localparam logic [1:0] KIND_VIBRATION = 2'd1;
  localparam logic [1:0] KIND_AUDIO     = 2'd2;
  // Spare code, sent like the other non-shock kinds
  localparam logic [1:0] KIND_UNUSED    = 2'd3;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] strength;
  } cmd_t;

  typedef struct packed {
    logic [15:0] low_us;
    logic [15:0] high_us;
    logic        last;
  } seg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ rtl/core/pdfe_front.sv @@
// ---------------------------------------------------------------------------
// pdfe_front
// Accepts commands, holds the transmitter id, builds the 16-bit frame word.
// ---------------------------------------------------------------------------
module pdfe_front
  import pdfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  cmd_t        in_data,
  input  q_status_t   q_stat,
  output logic        push,
  output logic [15:0] push_word
);

  logic [5:0] tx_id;
  logic [3:0] s;
  logic [4:0] sum;
  logic [3:0] chk;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_id <= 6'd0;
    end else if (cfg_wr_en) begin
      tx_id <= cfg_wr_data;
    end
  end

  // Non-shock kinds (including the unused code) send strength zero
  always_comb begin
    s   = (in_data.kind == KIND_SHOCK) ? in_data.strength : 4'd0;
    sum = CHK_BASE + {1'b0, s};
    chk = sum[3:0] + {3'd0, sum[4]};
    push_word = {tx_id, s[0], s[1], s[2], s[3], MID_CONST,
                 chk[2], chk[3], chk[0], chk[1]};
  end

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

endmodule

@@ rtl/core/pdfe_queue.sv @@
// ---------------------------------------------------------------------------
// pdfe_queue
// Short FIFO of frame words between the front and the segment sequencer.
// ---------------------------------------------------------------------------
module pdfe_queue
  import pdfe_pkg::*;
#(
  parameter int QDepth = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [15:0] push_word,
  input  logic        pop,
  output logic [15:0] pop_word,
  output q_status_t   q_stat
);

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  logic [15:0]     entries [QDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QDepth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QDepth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  assign pop_word     = entries[rd_ptr];
  assign q_stat.full  = (count == CntW'(QDepth));
  assign q_stat.empty = (count == '0);

endmodule

@@ rtl/core/pdfe_back.sv @@
// ---------------------------------------------------------------------------
// pdfe_back
// Segment sequencer: walks the 33 segments of a frame into an output register.
// ---------------------------------------------------------------------------
module pdfe_back
  import pdfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  q_status_t   q_stat,
  input  logic [15:0] pop_word,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output seg_t        out_data
);

  logic        active;
  logic [15:0] word;
  logic [5:0]  seg_idx;
  logic        advance;
  logic        emit;
  logic        emit_last;
  seg_t        seg;

  always_comb begin
    seg = '{low_us: END_GAP_US, high_us: 16'd0, last: 1'b1};
    if (seg_idx == SEG_SYNC) begin
      seg = '{low_us: SYNC_LOW_US, high_us: SYNC_HIGH_US, last: 1'b0};
    end else if (seg_idx <= SEG_TRAIN_LAST) begin
      seg = '{low_us: SYNC_LOW_US, high_us: TRAIN_HIGH_US, last: 1'b0};
    end else if (seg_idx == SEG_LEAD) begin
      seg = '{low_us: LEAD_LOW_US, high_us: PULSE_US, last: 1'b0};
    end else if (seg_idx >= SEG_DATA_FIRST && seg_idx <= SEG_DATA_LAST) begin
      // data bits MSB first: segment 16 carries word bit 15
      seg = '{low_us: word[~seg_idx[3:0]] ? ONE_GAP_US : ZERO_GAP_US,
              high_us: PULSE_US, last: 1'b0};
    end
  end

  assign advance   = !out_valid || !out_stall;
  assign emit      = advance && active;
  assign emit_last = emit && (seg_idx == SEG_END);
  assign pop       = advance && (!active || emit_last) && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      seg_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= active;
      end
      if (pop) begin
        active  <= 1'b1;
        seg_idx <= '0;
      end else if (emit_last) begin
        active <= 1'b0;
      end else if (emit) begin
        seg_idx <= seg_idx + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      word <= pop_word;
    end
    if (emit) begin
      out_data <= seg;
    end
  end

endmodule

@@ rtl/core/pulse_distance_frame_encoder.sv @@
// Timing: an accepted command's word is queued, then loaded into the segment
//   sequencer; the segments follow one per cycle while out is not stalled.
// Throughput: set by the segment sequencer, which emits one segment per cycle
//   while out is not stalled; the word queue lets commands arrive meanwhile.
// Reset (rst, synchronous): clears transmitter id, queue and sequencer; no
//   output is valid until a command has been taken.
// ---------------------------------------------------------------------------
// pulse_distance_frame_encoder
// Turns (kind, strength) commands into 33 low/high duration segments of a
// pulse-distance RF remote frame.
// ---------------------------------------------------------------------------
module pulse_distance_frame_encoder
  import pdfe_pkg::*;
#(
  parameter int QDepth = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  // configuration: transmitter id
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data,
  // command word in
  input  logic       in_valid,
  output logic       in_stall,
  input  cmd_t       in_data,
  // segment word out
  output logic       out_valid,
  input  logic       out_stall,
  output seg_t       out_data
);

  q_status_t   q_stat;
  logic        push;
  logic [15:0] push_word;
  logic        pop;
  logic [15:0] pop_word;

  // Front: classify the command and build the frame word, push it to the queue
  pdfe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_stat     (q_stat),
    .push       (push),
    .push_word  (push_word)
  );

  // Queue: hold built words so the front keeps taking commands while
  // the sequencer is busy or the output is stalled, until the queue fills
  pdfe_queue #(
    .QDepth(QDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_word(push_word),
    .pop      (pop),
    .pop_word (pop_word),
    .q_stat   (q_stat)
  );

  // Back: walk sync, train, lead, 16 data bits and end gap; pop the next
  // word in the same cycle the end gap goes out so frames run back to back
  pdfe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .pop_word (pop_word),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

@@ rtl/core/pdfe_checker.sv @@
// ---------------------------------------------------------------------------
// pdfe_checker
// Port-level checks for the frame encoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pdfe_checker
  import pdfe_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input cmd_t       in_data,
  input logic       out_valid,
  input logic       out_stall,
  input seg_t       out_data
);

  logic in_fire;

  assign in_fire = in_valid && !in_stall && (in_data.kind == in_data.kind);

  // Stalled output word holds.
  `PDFE_ASSERT(a_out_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(out_data)), "stalled output changed")
  // The end gap closes the frame with no high part.
  `PDFE_ASSERT_IMP(a_end_seg, clk, rst, out_valid && out_data.last, out_data.low_us == END_GAP_US && out_data.high_us == 16'd0, "bad end segment")
  // Every other segment has a high part.
  `PDFE_ASSERT_IMP(a_mid_seg, clk, rst, out_valid && !out_data.last, out_data.high_us != 16'd0, "missing high part")
  // After a frame ends, the next word shown opens a new frame with sync.
  `PDFE_ASSERT(a_next_sync, clk, rst, ((out_valid && !out_stall && out_data.last) ##1 (out_valid || in_fire)) |-> (!out_valid || (out_data.low_us == SYNC_LOW_US && out_data.high_us == SYNC_HIGH_US)), "frame does not start with sync")

endmodule

bind pulse_distance_frame_encoder pdfe_checker u_pdfe_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

@@ tb/pulse_distance_frame_encoder_tb.sv @@
// ---------------------------------------------------------------------------
// pulse_distance_frame_encoder_tb
// Self-checking bench for the pulse-distance frame encoder. Commands go in
// with random gaps while the segment side stalls at random. A scoreboard
// class expands every accepted command into its 33 expected segments and
// checks each accepted segment field by field, in order. The transmitter id
// is rewritten between phases, once the encoder has drained.
// ---------------------------------------------------------------------------
module pulse_distance_frame_encoder_tb;
  import pdfe_pkg::*;

  // Receiver hold-off used to back the encoder up into its command queue
  localparam int LONG_HOLD_CYCLES = 400;
  // Cycles to keep watching after the last segment, for stray words
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS = 40;

  // Scoreboard: predicts the segments of each command and checks the
  // segments the encoder emits against them, oldest first.
  class frame_tracker;
    logic [5:0] tx_id;
    seg_t segments_due[$];
    int failures;

    function new();
      tx_id = '0;
      failures = 0;
    endfunction

    function void set_id(logic [5:0] id);
      tx_id = id;
    endfunction

    function int pending();
      return segments_due.size();
    endfunction

    function logic [15:0] frame_word(cmd_t c);
      logic [3:0] s;
      logic [4:0] sum;
      logic [3:0] chk;
      s = (c.kind == KIND_SHOCK) ? c.strength : 4'd0;
      sum = CHK_BASE + {1'b0, s};
      // fold the carry back in; the result always fits in 4 bits
      chk = sum[3:0] + {3'b000, sum[4]};
      // strength goes in bit-reversed, checksum bits swapped pairwise
      return {tx_id, s[0], s[1], s[2], s[3], MID_CONST, chk[2], chk[3], chk[0], chk[1]};
    endfunction

    function void take_command(cmd_t c);
      logic [15:0] w;
      seg_t seg;
      w = frame_word(c);
      seg = '{low_us: SYNC_LOW_US, high_us: SYNC_HIGH_US, last: 1'b0};
      segments_due.push_back(seg);
      for (int k = SEG_SYNC + 1; k <= SEG_TRAIN_LAST; k++) begin
        seg = '{low_us: SYNC_LOW_US, high_us: TRAIN_HIGH_US, last: 1'b0};
        segments_due.push_back(seg);
      end
      seg = '{low_us: LEAD_LOW_US, high_us: PULSE_US, last: 1'b0};
      segments_due.push_back(seg);
      for (int i = 15; i >= 0; i--) begin
        seg = '{low_us: (w[i] ? ONE_GAP_US : ZERO_GAP_US), high_us: PULSE_US, last: 1'b0};
        segments_due.push_back(seg);
      end
      seg = '{low_us: END_GAP_US, high_us: 16'd0, last: 1'b1};
      segments_due.push_back(seg);
    endfunction

    function void match_segment(seg_t got);
      seg_t want;
      if (segments_due.size() == 0) begin
        $error("segment word with no command behind it: low_us %0d high_us %0d last %0d",
               got.low_us, got.high_us, got.last);
        failures++;
        return;
      end
      want = segments_due.pop_front();
      if (got.low_us !== want.low_us) begin
        $error("low_us: expected %0d, actual %0d", want.low_us, got.low_us);
        failures++;
      end
      if (got.high_us !== want.high_us) begin
        $error("high_us: expected %0d, actual %0d", want.high_us, got.high_us);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  logic [5:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  cmd_t       in_data;
  logic       out_valid;
  logic       out_stall;
  seg_t       out_data;

  frame_tracker tracker = new();

  // Set by the stimulus, cleared by the receiver when it starts a long hold
  bit hold_request = 1'b0;
  // When set, the sender offers words back to back
  bit no_gaps = 1'b0;

  pulse_distance_frame_encoder DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, some none, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Offer one command word and hold it until the encoder takes it. The
  // stall is sampled at the falling edge, where everything has settled;
  // the word is taken at the rising edge that follows.
  task automatic send_command(cmd_t c, int gap);
    bit taken;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    tracker.take_command(c);
  endtask

  // Drop valid, wait until every predicted segment has come out, then let
  // the encoder settle before touching its register.
  task automatic drain_encoder();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_tx_id(logic [5:0] id);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= id;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tracker.set_id(id);
  endtask

  function automatic cmd_t random_command();
    cmd_t c;
    // favor shock so that strength and checksum get exercised
    c.kind = ($urandom_range(0, 9) < 6) ? KIND_SHOCK : 2'($urandom_range(1, 3));
    c.strength = 4'($urandom_range(0, 15));
    return c;
  endfunction

  // Receiver: alternate ready runs and stalls; now and then a calm stretch
  // with no stall at all, and one long hold when the stimulus asks for it.
  initial begin : receiver
    int ready_run;
    int stall_run;
    int r;
    out_stall <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      ready_run = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 8);
      r = $urandom_range(0, 99);
      if (r < 50) stall_run = 0;
      else if (r < 90) stall_run = $urandom_range(1, 3);
      else if (r < 98) stall_run = $urandom_range(4, 12);
      else stall_run = $urandom_range(20, 40);
      out_stall <= 1'b0;
      repeat (ready_run) @(posedge clk);
      if (stall_run > 0) begin
        out_stall <= 1'b1;
        repeat (stall_run) @(posedge clk);
      end
    end
  end

  // Monitor: a segment word moves at the rising edge after a falling edge
  // that sees valid high and stall low.
  initial begin : monitor
    forever begin
      @(negedge clk);
      if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0)
        tracker.match_segment(out_data);
    end
  end

  initial begin : stimulus
    cmd_t c;
    cmd_t directed[$];
    logic [5:0] id;
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with the id left at its reset value of zero:
    // strength extremes, the checksum carry (strength 12) and the largest
    // checksum (strength 11), single strength bits, and non-shock kinds
    // including the unused one, all of which must send strength zero.
    directed = '{
      '{kind: KIND_SHOCK,     strength: 4'd0},
      '{kind: KIND_SHOCK,     strength: 4'd15},
      '{kind: KIND_SHOCK,     strength: 4'd12},
      '{kind: KIND_SHOCK,     strength: 4'd11},
      '{kind: KIND_SHOCK,     strength: 4'd1},
      '{kind: KIND_SHOCK,     strength: 4'd2},
      '{kind: KIND_SHOCK,     strength: 4'd4},
      '{kind: KIND_SHOCK,     strength: 4'd8},
      '{kind: KIND_SHOCK,     strength: 4'd13},
      '{kind: KIND_VIBRATION, strength: 4'd15},
      '{kind: KIND_AUDIO,     strength: 4'd15},
      '{kind: KIND_UNUSED,    strength: 4'd15},
      '{kind: KIND_VIBRATION, strength: 4'd0},
      '{kind: KIND_AUDIO,     strength: 4'd0},
      '{kind: KIND_UNUSED,    strength: 4'd10},
      '{kind: KIND_SHOCK,     strength: 4'd7}
    };
    foreach (directed[i]) send_command(directed[i], pick_gap());
    drain_encoder();

    // Random phases, each under its own transmitter id: both extremes
    // first, then values in between.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          id = 6'd63;
        end
        1: begin
          id = 6'd0;
        end
        default: begin
          id = 6'($urandom_range(1, 62));
        end
      endcase
      write_tx_id(id);
      // one phase backs the encoder up with a long hold; two send with no gaps
      no_gaps = (p == 2 || p == 3);
      if (p == 2) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        c = random_command();
        send_command(c, no_gaps ? 0 : pick_gap());
      end
      drain_encoder();
    end

    // Keep watching for stray words, then report.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: a generous bound over the slowest legal run.
  initial begin : watchdog
    #12000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
